// ===== rtl/dart_pkg.sv =====
package dart_pkg;

    // Command codes carried in the cmd field.
    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    // Register select codes.
    localparam logic [1:0] SEL_DIVIDER = 2'd0;
    localparam logic [1:0] SEL_COUNT   = 2'd1;
    localparam logic [1:0] SEL_RELOAD  = 2'd2;
    localparam logic [1:0] SEL_CONTROL = 2'd3;

    // Control register layout.
    localparam int unsigned CTL_ENABLE_BIT = 2;

    // Timer period codes held in control bits 1:0.
    localparam logic [1:0] PERIOD_1024 = 2'd0;
    localparam logic [1:0] PERIOD_16   = 2'd1;
    localparam logic [1:0] PERIOD_64   = 2'd2;

    // One input beat.
    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] clocks;
        logic [1:0] reg_select;
        logic [7:0] write_data;
    } in_t;

    // One result beat.
    typedef struct packed {
        logic [7:0] read_data;
        logic       timer_interrupt;
    } out_t;

endpackage

// ===== rtl/dart_core.sv =====
module dart_core
    import dart_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic beat,
    input  in_t  item,
    output out_t result
);

    logic [7:0]  div_pre_reg, div_pre_next;
    logic [7:0]  div_val_reg, div_val_next;
    logic [10:0] tim_pre_reg, tim_pre_next;
    logic [7:0]  tim_cnt_reg, tim_cnt_next;
    logic [7:0]  reload_reg, reload_next;
    logic [2:0]  ctl_reg, ctl_next;

    logic [8:0]  div_sum;
    logic [11:0] tim_sum;
    logic [11:0] period;
    logic [10:0] tim_rem;
    logic        tim_step;

    // The period is always a power of two, so the remainder is a mask.
    function automatic logic [11:0] timer_period(input logic [1:0] code);
        logic [11:0] p;
        case (code)
            PERIOD_1024: p = 12'd1024;
            PERIOD_16:   p = 12'd16;
            PERIOD_64:   p = 12'd64;
            default:     p = 12'd256;
        endcase
        return p;
    endfunction

    // Prescaler sums for both counters, and the timer period, remainder and step.
    always_comb begin
        div_sum  = {1'b0, div_pre_reg} + {1'b0, item.clocks};
        period   = timer_period(ctl_reg[1:0]);
        tim_sum  = {1'b0, tim_pre_reg} + {4'b0, item.clocks};
        tim_rem  = tim_sum[10:0] & (period[10:0] - 11'd1);
        tim_step = (tim_sum >= period);
    end

    // Next state and result for the beat being taken.
    always_comb begin
        div_pre_next = div_pre_reg;
        div_val_next = div_val_reg;
        tim_pre_next = tim_pre_reg;
        tim_cnt_next = tim_cnt_reg;
        reload_next  = reload_reg;
        ctl_next     = ctl_reg;
        result       = '0;

        case (item.cmd)
            CMD_TICK: begin
                div_pre_next = div_sum[7:0];
                if (div_sum[8]) begin
                    div_val_next = div_val_reg + 8'd1;
                end
                if (ctl_reg[CTL_ENABLE_BIT]) begin
                    tim_pre_next = tim_rem;
                    if (tim_step) begin
                        if (tim_cnt_reg == 8'hFF) begin
                            tim_cnt_next           = reload_reg;
                            result.timer_interrupt = 1'b1;
                        end else begin
                            tim_cnt_next = tim_cnt_reg + 8'd1;
                        end
                    end
                end
            end
            CMD_WRITE: begin
                unique case (item.reg_select)
                    SEL_DIVIDER: div_val_next = item.write_data;
                    SEL_COUNT:   tim_cnt_next = item.write_data;
                    SEL_RELOAD:  reload_next  = item.write_data;
                    SEL_CONTROL: ctl_next     = item.write_data[2:0];
                    default:     ctl_next     = ctl_reg;
                endcase
            end
            CMD_READ: begin
                unique case (item.reg_select)
                    SEL_DIVIDER: result.read_data = div_val_reg;
                    SEL_COUNT:   result.read_data = tim_cnt_reg;
                    SEL_RELOAD:  result.read_data = reload_reg;
                    SEL_CONTROL: result.read_data = {5'b0, ctl_reg};
                    default:     result.read_data = 8'd0;
                endcase
            end
            default: begin
                result = '0;
            end
        endcase
    end

    // Timer state, advanced only on an accepted beat.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            div_pre_reg <= '0;
            div_val_reg <= '0;
            tim_pre_reg <= '0;
            tim_cnt_reg <= '0;
            reload_reg  <= '0;
            ctl_reg     <= '0;
        end else if (beat) begin
            div_pre_reg <= div_pre_next;
            div_val_reg <= div_val_next;
            tim_pre_reg <= tim_pre_next;
            tim_cnt_reg <= tim_cnt_next;
            reload_reg  <= reload_next;
            ctl_reg     <= ctl_next;
        end
    end

endmodule

// ===== rtl/dart_skid.sv =====
module dart_skid
    import dart_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic in_valid,
    output logic in_ready,
    input  out_t in_data,
    output logic out_valid,
    input  logic out_ready,
    output out_t out_data
);

    logic out_valid_reg, out_valid_next;
    logic skid_valid_reg, skid_valid_next;
    out_t out_data_reg, out_data_next;
    out_t skid_data_reg, skid_data_next;
    logic take;

    assign in_ready  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign take      = out_valid_reg && out_ready;

    // Drain first, then place the new beat in the first free entry.
    always_comb begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;
        if (take) begin
            if (skid_valid_reg) begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end else begin
                out_valid_next = 1'b0;
            end
        end
        if (in_valid && in_ready) begin
            if (!out_valid_next) begin
                out_data_next  = in_data;
                out_valid_next = 1'b1;
            end else begin
                skid_data_next  = in_data;
                skid_valid_next = 1'b1;
            end
        end
    end

    // Occupancy flags.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // Payload entries need no reset.
    always_ff @(posedge aclk) begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

endmodule

// ===== rtl/divider_and_reload_timer.sv =====
// Channel   Direction  Handshake           Payload
// s_        in         s_valid / s_ready   s_data (in_t: cmd, clocks, reg_select, write_data)
// m_        out        m_valid / m_ready   m_data (out_t: read_data, timer_interrupt)
//
// One beat is accepted every cycle while s_ready is high; its result reaches m_ through a register.
// The timer state and result logic is a single add-compare-mask pass per beat.
// Reset is synchronous on aresetn and clears the timer state and output buffer.
// A two-entry output buffer keeps s_ready registered; it falls only when both
// entries hold results that m_ has not yet taken.
module divider_and_reload_timer
    import dart_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  in_t  s_data,
    output logic m_valid,
    input  logic m_ready,
    output out_t m_data
);

    logic beat;
    out_t core_result;

    assign beat = s_valid && s_ready;

    // Timer state and per-beat result.
    dart_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .beat    (beat),
        .item    (s_data),
        .result  (core_result)
    );

    // Output buffer between the two sides.
    dart_skid u_skid (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (beat),
        .in_ready  (s_ready),
        .in_data   (core_result),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (m_data)
    );

    // An accepted beat always leaves a result waiting.
    a_beat_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        beat |=> m_valid)
        else $error("accepted beat produced no result");

    // Back-pressure only while a result is pending on m_.
    a_stall_needs_result: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid)
        else $error("input stalled with no result pending");

    // Only a tick can raise the interrupt.
    a_irq_on_tick_only: assert property (@(posedge aclk) disable iff (!aresetn)
        beat && (s_data.cmd != CMD_TICK) |-> !core_result.timer_interrupt)
        else $error("interrupt raised by a non-tick beat");

    // Read data is zero on anything but a read.
    a_data_on_read_only: assert property (@(posedge aclk) disable iff (!aresetn)
        beat && (s_data.cmd != CMD_READ) |-> (core_result.read_data == 8'd0))
        else $error("read data non-zero on a non-read beat");

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
    import dart_pkg::*;

    // Command code with no function and the period code that the package leaves unnamed.
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam logic [1:0] PERIOD_256 = 2'd3;

    // Cycles without any accepted beat before the run is abandoned.
    localparam int unsigned STALL_LIMIT = 2000;

    logic aclk;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    in_t  s_data;
    logic m_valid;
    logic m_ready;
    out_t m_data;

    // Shadow copy of the timer state, advanced once per accepted input beat.
    logic [7:0]  shadow_div_prescale = '0;
    logic [7:0]  shadow_div_value    = '0;
    logic [10:0] shadow_tmr_prescale = '0;
    logic [7:0]  shadow_tmr_count    = '0;
    logic [7:0]  shadow_reload       = '0;
    logic [2:0]  shadow_control      = '0;

    out_t        pending_results[$];
    int unsigned error_count  = 0;
    int unsigned quiet_cycles = 0;
    bit          sender_idles   = 1'b1;
    bit          receiver_idles = 1'b1;

    divider_and_reload_timer uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // Clock generation.
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Works out the result of one beat and advances the shadow state.
    function automatic out_t predict_timer_result(input in_t beat);
        out_t res;
        int   sum;
        int   period;
        res = '0;
        case (beat.cmd)
            CMD_TICK: begin
                sum = int'(shadow_div_prescale) + int'(beat.clocks);
                if (sum >= 256) shadow_div_value = shadow_div_value + 8'd1;
                shadow_div_prescale = sum[7:0];
                if (shadow_control[CTL_ENABLE_BIT]) begin
                    case (shadow_control[1:0])
                        PERIOD_1024: period = 1024;
                        PERIOD_16:   period = 16;
                        PERIOD_64:   period = 64;
                        default:     period = 256;
                    endcase
                    sum = int'(shadow_tmr_prescale) + int'(beat.clocks);
                    if (sum >= period) begin
                        if (shadow_tmr_count == 8'hFF) begin
                            shadow_tmr_count = shadow_reload;
                            res.timer_interrupt = 1'b1;
                        end else begin
                            shadow_tmr_count = shadow_tmr_count + 8'd1;
                        end
                    end
                    shadow_tmr_prescale = 11'(sum % period);
                end
            end
            CMD_WRITE: begin
                case (beat.reg_select)
                    SEL_DIVIDER: shadow_div_value = beat.write_data;
                    SEL_COUNT:   shadow_tmr_count = beat.write_data;
                    SEL_RELOAD:  shadow_reload    = beat.write_data;
                    default:     shadow_control   = beat.write_data[2:0];
                endcase
            end
            CMD_READ: begin
                case (beat.reg_select)
                    SEL_DIVIDER: res.read_data = shadow_div_value;
                    SEL_COUNT:   res.read_data = shadow_tmr_count;
                    SEL_RELOAD:  res.read_data = shadow_reload;
                    default:     res.read_data = {5'b0, shadow_control};
                endcase
            end
            default: begin
            end
        endcase
        return res;
    endfunction

    // Beat builders; fields that the command ignores carry random values.
    function automatic in_t make_tick(input logic [7:0] clocks);
        return '{cmd: CMD_TICK, clocks: clocks, reg_select: 2'($urandom),
                 write_data: 8'($urandom)};
    endfunction

    function automatic in_t make_write(input logic [1:0] sel, input logic [7:0] data);
        return '{cmd: CMD_WRITE, clocks: 8'($urandom), reg_select: sel, write_data: data};
    endfunction

    function automatic in_t make_read(input logic [1:0] sel);
        return '{cmd: CMD_READ, clocks: 8'($urandom), reg_select: sel,
                 write_data: 8'($urandom)};
    endfunction

    // Random beat, weighted towards ticks and towards settings that make the count wrap.
    function automatic in_t random_beat();
        in_t        beat;
        int         pick;
        logic [1:0] sel;
        logic [7:0] data;
        pick = $urandom_range(0, 99);
        sel  = 2'($urandom_range(0, 3));
        data = 8'($urandom);
        if (pick < 55) begin
            if ($urandom_range(0, 7) == 0) begin
                beat = make_tick($urandom_range(0, 1) ? 8'hFF : 8'h00);
            end else begin
                beat = make_tick(data);
            end
        end else if (pick < 75) begin
            if (sel == SEL_COUNT && $urandom_range(0, 1) == 1) begin
                data = 8'($urandom_range(240, 255));
            end
            if (sel == SEL_CONTROL && $urandom_range(0, 4) != 0) begin
                data[CTL_ENABLE_BIT] = 1'b1;
            end
            beat = make_write(sel, data);
        end else if (pick < 96) begin
            beat = make_read(sel);
        end else begin
            beat = '{cmd: CMD_UNUSED, clocks: 8'($urandom), reg_select: sel, write_data: data};
        end
        return beat;
    endfunction

    // Presents one beat, holding it until accepted, and records its expected result.
    // Valid is lowered only for an idle gap, so back-to-back beats keep it high.
    task automatic send_beat(input in_t beat);
        if (sender_idles && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= beat;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_results.push_back(predict_timer_result(beat));
    endtask

    // Stops sending until every outstanding result has been taken.
    task automatic wait_for_drain();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    // Register extremes, every command, divider and count overflow, reload with
    // interrupt, each period, a period shrunk under a large prescaler, the unused command.
    task automatic run_directed();
        send_beat(make_read(SEL_DIVIDER));
        send_beat(make_read(SEL_COUNT));
        send_beat(make_read(SEL_RELOAD));
        send_beat(make_read(SEL_CONTROL));
        send_beat(make_write(SEL_RELOAD, 8'hA5));
        send_beat(make_write(SEL_CONTROL, 8'hFF));
        send_beat(make_read(SEL_CONTROL));
        send_beat(make_write(SEL_COUNT, 8'hFF));
        send_beat(make_tick(8'hFF));
        send_beat(make_tick(8'h01));
        send_beat(make_read(SEL_COUNT));
        send_beat(make_write(SEL_CONTROL, {5'b0, 1'b1, PERIOD_1024}));
        repeat (3) send_beat(make_tick(8'hFF));
        send_beat(make_write(SEL_CONTROL, {5'b0, 1'b1, PERIOD_16}));
        send_beat(make_tick(8'h00));
        send_beat(make_write(SEL_CONTROL, {5'b0, 1'b1, PERIOD_64}));
        send_beat(make_tick(8'd200));
        send_beat('{cmd: CMD_UNUSED, clocks: 8'hFF, reg_select: 2'b11, write_data: 8'hFF});
        send_beat(make_write(SEL_DIVIDER, 8'h00));
        send_beat(make_write(SEL_RELOAD, 8'h00));
        send_beat(make_write(SEL_CONTROL, {5'b0, 1'b0, PERIOD_256}));
        send_beat(make_tick(8'hFF));
        send_beat(make_read(SEL_DIVIDER));
    endtask

    // Mixed random traffic with idling on both sides.
    task automatic run_random_mix(input int unsigned count);
        repeat (count) send_beat(random_beat());
    endtask

    // Random traffic after the pipeline has been allowed to empty completely.
    task automatic run_after_pause(input int unsigned count);
        wait_for_drain();
        repeat (count) send_beat(random_beat());
    endtask

    // Closing stretch with neither side idling.
    task automatic run_back_to_back(input int unsigned count);
        sender_idles   = 1'b0;
        receiver_idles = 1'b0;
        repeat (count) send_beat(random_beat());
    endtask

    // Receiver: ready with random stall bursts while idling is enabled.
    initial begin
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (receiver_idles && $urandom_range(0, 7) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge aclk);
            end
            m_ready <= 1'b1;
        end
    end

    // Result check against the oldest expectation.
    always @(posedge aclk) begin
        out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                error_count++;
                $display("%0t: result with none expected: read_data %0h timer_interrupt %0b",
                         $time, m_data.read_data, m_data.timer_interrupt);
            end else begin
                want = pending_results.pop_front();
                if (m_data.read_data !== want.read_data) begin
                    error_count++;
                    $display("%0t: read_data expected %0h actual %0h",
                             $time, want.read_data, m_data.read_data);
                end
                if (m_data.timer_interrupt !== want.timer_interrupt) begin
                    error_count++;
                    $display("%0t: timer_interrupt expected %0b actual %0b",
                             $time, want.timer_interrupt, m_data.timer_interrupt);
                end
            end
        end
    end

    // Watchdog on cycles with no beat accepted on either channel.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
            $display("status: fail");
            $finish;
        end
    end

    // Test sequence.
    initial begin
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_data  <= '0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        run_directed();
        run_random_mix(300);
        run_after_pause(100);
        run_back_to_back(125);

        wait_for_drain();
        repeat (4) @(posedge aclk);
        if (error_count == 0 && pending_results.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
